FILE: rtl/entropy_bit_pool_dice_roller_unit_macros.svh
// assertion macros used by the checker of the dice roller unit
`ifndef ENTROPY_BIT_POOL_DICE_ROLLER_UNIT_MACROS_SVH
`define ENTROPY_BIT_POOL_DICE_ROLLER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define EBPDR_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define EBPDR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/ebpdr_pkg.sv
// shared constants and types of the entropy pool dice roller
`timescale 1ns / 1ps
package ebpdr_pkg;

  localparam int POOL_BITS        = 128;
  localparam int DEPOSIT_MAX_BITS = 32;

  localparam int ADDR_W     = $clog2(POOL_BITS);
  localparam int FILL_W     = $clog2(POOL_BITS + 1);
  localparam int CNT_MAX    = (DEPOSIT_MAX_BITS > 8) ? DEPOSIT_MAX_BITS : 8;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int PULSE_W    = 32;
  localparam int RAND_W     = 32;
  localparam int OP_W       = 2;
  localparam int RANGE_W    = 8;
  localparam int ROLL_W     = 9;
  localparam int ROLL_MIN   = 2;
  localparam int ROLL_RESET = 2;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = PULSE_W + RAND_W;
  localparam int OUT_DATA_W = 2 * BYTE_W;

  typedef enum logic [OP_W-1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_ROLL    = 2'd2
  } op_e;

  // sequencer to roller step unit
  typedef struct packed {
    logic step;
    logic bit_val;
  } roll_ctrl_t;

  // roller step unit back to sequencer
  typedef struct packed {
    logic              accept;
    logic [BYTE_W-1:0] value;
  } roll_stat_t;

endpackage

FILE: rtl/ebpdr_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
module ebpdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/ebpdr_roller.sv
// fast dice roller step unit: one pool bit per step, holds range, bound and candidate
`timescale 1ns / 1ps
module ebpdr_roller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ebpdr_pkg::RANGE_W-1:0] cfg_data_i,
  input  ebpdr_pkg::roll_ctrl_t        ctrl_i,
  output ebpdr_pkg::roll_stat_t        stat_o
);
  import ebpdr_pkg::*;

  logic [RANGE_W-1:0] range_q, range_d;
  logic [ROLL_W-1:0]  bound_q, bound_d;
  logic [ROLL_W-1:0]  cand_q, cand_d;
  logic [ROLL_W-1:0]  n;
  logic [ROLL_W-1:0]  bound_sh;
  logic [ROLL_W-1:0]  cand_sh;
  logic               hit;
  logic               acc;

  // range below two counts as two
  assign n = (range_q < RANGE_W'(ROLL_MIN)) ? ROLL_W'(ROLL_MIN) : ROLL_W'(range_q);

  // double the bound, shift the bit into the candidate, compare with the range
  assign bound_sh = {bound_q[ROLL_W-2:0], 1'b0};
  assign cand_sh  = {cand_q[ROLL_W-2:0], ctrl_i.bit_val};
  assign hit      = (bound_sh >= n);
  assign acc      = hit && (cand_sh < n);

  assign stat_o.accept = ctrl_i.step && acc;
  assign stat_o.value  = cand_sh[BYTE_W-1:0];

  // next roller state
  always_comb begin
    range_d = range_q;
    bound_d = bound_q;
    cand_d  = cand_q;
    if (cfg_we_i) begin
      range_d = cfg_data_i;
      bound_d = ROLL_W'(1);
      cand_d  = '0;
    end else if (ctrl_i.step) begin
      if (acc) begin
        bound_d = ROLL_W'(1);
        cand_d  = '0;
      end else if (hit) begin
        bound_d = bound_sh - n;
        cand_d  = cand_sh - n;
      end else begin
        bound_d = bound_sh;
        cand_d  = cand_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_W'(ROLL_RESET);
      bound_q <= ROLL_W'(1);
      cand_q  <= '0;
    end else begin
      range_q <= range_d;
      bound_q <= bound_d;
      cand_q  <= cand_d;
    end
  end

endmodule

FILE: rtl/entropy_bit_pool_dice_roller_unit.sv
// Entropy bit pool with fast dice roller: top level and sequencer
//
// Input stream (s_axis): tuser carries the operation (deposit, read byte, roll),
// tdata carries pulse_count and random_bits. Output stream (m_axis): one result
// per item, tuser is the ready flag, tdata holds the value and the pool fill.
// Configuration: cfg_valid_i/cfg_data_i write roll_range; cfg_ready_o is always
// high and a write restarts the roller. Write it only while the block is idle.
// The pool is a 128 x 1 ram used as a stack; pushed bits enter its write port
// one per cycle, and a popped bit takes a read and a use state on its read port.
// Deposit pushes up to 32 bits, read byte pops eight, roll pops bits until the
// roller accepts or the pool empties; a short read, empty roll or unused code
// goes straight to the result. One item at a time; s_axis_tready_o is low meanwhile.
// A finished result sits in an output register; if the receiver stalls with a
// result still held, the next result waits in the sequencer until it is taken.
// Reset empties the pool, clears the last pulse count, sets the range to two
// and restarts the roller; the ram contents need no clearing.
`timescale 1ns / 1ps
module entropy_bit_pool_dice_roller_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] pulse_count, [63:32] random_bits
  input  logic [ebpdr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] operation
  input  logic [ebpdr_pkg::OP_W-1:0]       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] value, [15:8] bits_available
  output logic [ebpdr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] ready_res
  output logic                             m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ebpdr_pkg::RANGE_W-1:0]    cfg_data_i
);
  import ebpdr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEP_CNT,
    ST_DEP_PUSH,
    ST_POP_RD,
    ST_POP_USE,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [PULSE_W-1:0]  pulse_q, pulse_d;
  logic [RAND_W-1:0]   bits_q, bits_d;
  logic [PULSE_W-1:0]  last_q, last_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic                res_rdy_q, res_rdy_d;
  logic [BYTE_W-1:0]   res_val_q, res_val_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                m_user_q, m_user_d;

  logic                s_xfer;
  logic [PULSE_W-1:0]  delta;
  logic [PULSE_W:0]    dbl;
  logic [FILL_W-1:0]   fill_dec;
  logic [BYTE_W-1:0]   byte_next;
  logic                pool_full;
  logic                ram_we;
  logic                ram_re;
  logic [0:0]          ram_rdata;
  roll_ctrl_t          roll_ctrl;
  roll_stat_t          roll_stat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // deposit bit count: twice the wrapped pulse delta, capped
  assign delta     = pulse_q - last_q;
  assign dbl       = {delta, 1'b0};
  assign fill_dec  = fill_q - FILL_W'(1);
  assign pool_full = (fill_q >= FILL_W'(POOL_BITS));
  assign byte_next = {ram_rdata[0], byte_q[BYTE_W-1:1]};

  // pool stack storage
  assign ram_we = (state_q == ST_DEP_PUSH) && !pool_full;
  assign ram_re = (state_q == ST_POP_RD);

  ebpdr_ram #(
    .WIDTH (1),
    .DEPTH (POOL_BITS)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (bits_q[0]),
    .re_i    (ram_re),
    .raddr_i (fill_dec[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // roller step unit, stepped only for roll items
  assign roll_ctrl.step    = (state_q == ST_POP_USE) && (op_q == OP_ROLL);
  assign roll_ctrl.bit_val = ram_rdata[0];

  ebpdr_roller u_roller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (roll_ctrl),
    .stat_o     (roll_stat)
  );

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pulse_d   = pulse_q;
    bits_d    = bits_q;
    last_d    = last_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    byte_d    = byte_q;
    res_rdy_d = res_rdy_q;
    res_val_d = res_val_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    // output transfer frees the result register
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          op_d      = op_e'(s_axis_tuser_i);
          pulse_d   = s_axis_tdata_i[PULSE_W-1:0];
          bits_d    = s_axis_tdata_i[IN_DATA_W-1:PULSE_W];
          res_rdy_d = 1'b0;
          res_val_d = '0;
          byte_d    = '0;
          unique case (op_e'(s_axis_tuser_i))
            OP_DEPOSIT: begin
              res_rdy_d = 1'b1;
              state_d   = ST_DEP_CNT;
            end
            OP_READ: begin
              cnt_d = CNT_W'(BYTE_W);
              if (fill_q >= FILL_W'(BYTE_W)) begin
                state_d = ST_POP_RD;
              end else begin
                state_d = ST_FINISH;
              end
            end
            OP_ROLL: begin
              if (fill_q != '0) begin
                state_d = ST_POP_RD;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_DEP_CNT: begin
        last_d = pulse_q;
        if (dbl > (PULSE_W + 1)'(DEPOSIT_MAX_BITS)) begin
          cnt_d = CNT_W'(DEPOSIT_MAX_BITS);
        end else begin
          cnt_d = dbl[CNT_W-1:0];
        end
        if (dbl == '0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_DEP_PUSH;
        end
      end
      ST_DEP_PUSH: begin
        if (!pool_full) begin
          fill_d = fill_q + FILL_W'(1);
        end
        bits_d = bits_q >> 1;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_POP_RD: begin
        state_d = ST_POP_USE;
      end
      ST_POP_USE: begin
        fill_d = fill_dec;
        if (op_q == OP_READ) begin
          byte_d = byte_next;
          cnt_d  = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            res_rdy_d = 1'b1;
            res_val_d = byte_next;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_POP_RD;
          end
        end else begin
          if (roll_stat.accept) begin
            res_rdy_d = 1'b1;
            res_val_d = roll_stat.value;
            state_d   = ST_FINISH;
          end else if (fill_dec == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_POP_RD;
          end
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = res_rdy_q;
          m_data_d  = {BYTE_W'(fill_q), res_val_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      last_q    <= last_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pulse_q   <= pulse_d;
    bits_q    <= bits_d;
    cnt_q     <= cnt_d;
    byte_q    <= byte_d;
    res_rdy_q <= res_rdy_d;
    res_val_q <= res_val_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

endmodule

FILE: rtl/ebpdr_checker.sv
// port-level checker for the dice roller unit, bound to the top level
`timescale 1ns / 1ps
`include "entropy_bit_pool_dice_roller_unit_macros.svh"
module ebpdr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [ebpdr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import ebpdr_pkg::*;

  // a stalled result holds its payload
  `EBPDR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && m_axis_tvalid_o)
  // one item at a time: an input transfer closes the input side
  `EBPDR_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // pool fill never exceeds its size
  `EBPDR_ASSERT_NOW(a_fill_range, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[OUT_DATA_W-1:BYTE_W] <= BYTE_W'(POOL_BITS))
  // no value without the ready flag
  `EBPDR_ASSERT_NOW(a_value_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[BYTE_W-1:0] == '0)

endmodule

bind entropy_bit_pool_dice_roller_unit ebpdr_checker u_ebpdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
